// File: sv/mwm_pkg.sv
// Shared constants and types for the mecanum wheel mixer.
// Widths of the mixing, magnitude, product and quotient paths; no dependencies.
`timescale 1ns / 1ps

package mwm_pkg;

  localparam int WHEELS     = 4;
  localparam int VEL_W      = 16;
  localparam int MIX_W      = VEL_W + 2;       // sum of three 16-bit terms
  localparam int MAG_W      = MIX_W - 1;       // magnitude up to 3 * 32768
  localparam int LIM_W      = 15;
  localparam int PROD_W     = MAG_W + LIM_W;
  localparam int QUO_W      = LIM_W;           // quotient never exceeds the limit
  localparam int DIV_STAGES = QUO_W;           // one quotient bit per stage
  localparam int PIPE_DEPTH = 3 + DIV_STAGES;  // stages ahead of the output register

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(255);

  // Wheel order on every vector: front left, front right, rear left, rear right
  localparam int FL = 0;
  localparam int FR = 1;
  localparam int RL = 2;
  localparam int RR = 3;

  typedef logic [WHEELS-1:0][MIX_W-1:0]  mix_vec_t;
  typedef logic [WHEELS-1:0][MAG_W-1:0]  mag_vec_t;
  typedef logic [WHEELS-1:0][VEL_W-1:0]  wheel_vec_t;
  typedef logic [WHEELS-1:0][PROD_W-1:0] prod_vec_t;
  typedef logic [WHEELS-1:0][QUO_W-1:0]  quo_vec_t;

  // Per-item data that rides alongside the divider
  typedef struct packed {
    logic              scale;
    logic [WHEELS-1:0] neg;
    wheel_vec_t        wlow;
  } side_t;

endpackage

// File: sv/mwm_mix.sv
// Mixing stages: body command to four wheel sums, then magnitudes and pair maxima.
// Uses mwm_pkg.
`timescale 1ns / 1ps

module mwm_mix
  import mwm_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [VEL_W-1:0] vel_forward,
  input  logic signed [VEL_W-1:0] vel_sideways,
  input  logic signed [VEL_W-1:0] vel_rotate,
  output mag_vec_t                mag,
  output logic [WHEELS-1:0]       neg,
  output wheel_vec_t              wlow,
  output logic [MAG_W-1:0]        max_front,
  output logic [MAG_W-1:0]        max_rear
);

  logic signed [MIX_W-1:0] fwd_x, side_x, rot_x;
  mix_vec_t                mix_next;
  mix_vec_t                mix;
  mag_vec_t                mag_next;
  logic [MIX_W-1:0]        negated [WHEELS];

  assign fwd_x  = MIX_W'(vel_forward);
  assign side_x = MIX_W'(vel_sideways);
  assign rot_x  = MIX_W'(vel_rotate);

  always_comb begin
    mix_next[FL] = fwd_x - side_x - rot_x;
    mix_next[FR] = fwd_x + side_x + rot_x;
    mix_next[RL] = fwd_x + side_x - rot_x;
    mix_next[RR] = fwd_x - side_x + rot_x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mix <= mix_next;
    end
  end

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      negated[i]  = ~mix[i] + MIX_W'(1);
      mag_next[i] = mix[i][MIX_W-1] ? negated[i][MAG_W-1:0] : mix[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag       <= mag_next;
      for (int i = 0; i < WHEELS; i++) begin
        neg[i]  <= mix[i][MIX_W-1];
        wlow[i] <= mix[i][VEL_W-1:0];
      end
      max_front <= (mag_next[FL] > mag_next[FR]) ? mag_next[FL] : mag_next[FR];
      max_rear  <= (mag_next[RL] > mag_next[RR]) ? mag_next[RL] : mag_next[RR];
    end
  end

endmodule

// File: sv/mwm_mult.sv
// Largest-magnitude pick, limit compare and the four magnitude * limit products.
// Uses mwm_pkg.
`timescale 1ns / 1ps

module mwm_mult
  import mwm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [LIM_W-1:0]  speed_limit,
  input  mag_vec_t          mag,
  input  logic [WHEELS-1:0] neg,
  input  wheel_vec_t        wlow,
  input  logic [MAG_W-1:0]  max_front,
  input  logic [MAG_W-1:0]  max_rear,
  output prod_vec_t         prod,
  output logic [MAG_W-1:0]  largest,
  output side_t             side
);

  logic [MAG_W-1:0] largest_next;

  assign largest_next = (max_front > max_rear) ? max_front : max_rear;

  always_ff @(posedge clk) begin
    if (en) begin
      largest    <= largest_next;
      side.scale <= largest_next > MAG_W'(speed_limit);
      side.neg   <= neg;
      side.wlow  <= wlow;
      for (int i = 0; i < WHEELS; i++) begin
        prod[i] <= PROD_W'(mag[i]) * PROD_W'(speed_limit);
      end
    end
  end

endmodule

// File: sv/mwm_div.sv
// Pipelined restoring divider for one wheel, one quotient bit per stage.
// The dividend is known to give a quotient below 2**QUO_W. Uses mwm_pkg.
`timescale 1ns / 1ps

module mwm_div
  import mwm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [PROD_W-1:0] dividend,
  input  logic [MAG_W-1:0]  divisor,
  output logic [QUO_W-1:0]  quotient
);

  logic [MAG_W-1:0] rem [DIV_STAGES+1];
  logic [QUO_W-1:0] low [DIV_STAGES+1];
  logic [QUO_W-1:0] quo [DIV_STAGES+1];
  logic [MAG_W-1:0] dv  [DIV_STAGES+1];

  // Top bits start below the divisor, so the remainder always fits MAG_W
  assign rem[0] = dividend[PROD_W-1:QUO_W];
  assign low[0] = dividend[QUO_W-1:0];
  assign quo[0] = '0;
  assign dv[0]  = divisor;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [MAG_W:0] trial;
    logic           fits;

    assign trial = {rem[k], low[k][QUO_W-1]};
    assign fits  = trial >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= fits ? MAG_W'(trial - {1'b0, dv[k]}) : trial[MAG_W-1:0];
        low[k+1] <= {low[k][QUO_W-2:0], 1'b0};
        quo[k+1] <= {quo[k][QUO_W-2:0], fits};
        dv[k+1]  <= dv[k];
      end
    end
  end

  assign quotient = quo[DIV_STAGES];

endmodule

// File: sv/mecanum_wheel_mixer.sv
// Mecanum wheel mixer top level: inverse kinematics with proportional limiting.
// Uses mwm_pkg, mwm_mix, mwm_mult and mwm_div.
//
// Usage:
//   Input channel (in_valid / in_stall) carries a body command: vel_forward,
//   vel_sideways, vel_rotate. Output channel (out_valid / out_stall) carries
//   front_left, front_right, rear_left, rear_right. A transaction completes on
//   an edge with valid high and stall low.
//   Config channel (cfg_valid / cfg_ready, cfg_data) writes speed_limit; it is
//   always ready. Write only while no command is in flight.
//   From input transaction to result on the output register, a command passes
//   two mixing stages, one multiply stage, fifteen divider stages (one
//   quotient bit each) and the output register. Throughput is one command
//   per cycle while the output is not stalled.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall is raised; nothing is dropped or repeated.
//   Reset clears all valid bits and loads speed_limit with 255.
`timescale 1ns / 1ps

module mecanum_wheel_mixer
  import mwm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VEL_W-1:0] vel_forward,
  input  logic signed [VEL_W-1:0] vel_sideways,
  input  logic signed [VEL_W-1:0] vel_rotate,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VEL_W-1:0] front_left,
  output logic signed [VEL_W-1:0] front_right,
  output logic signed [VEL_W-1:0] rear_left,
  output logic signed [VEL_W-1:0] rear_right,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [LIM_W-1:0]        cfg_data
);

  logic                   en;
  logic [LIM_W-1:0]       speed_limit;
  logic [PIPE_DEPTH-1:0]  vpipe;

  mag_vec_t               mag;
  logic [WHEELS-1:0]      neg;
  wheel_vec_t             wlow;
  logic [MAG_W-1:0]       max_front, max_rear;
  prod_vec_t              prod;
  logic [MAG_W-1:0]       largest;
  side_t                  side;
  side_t                  side_d [DIV_STAGES];
  quo_vec_t               quo;
  wheel_vec_t             result_next;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      speed_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vpipe     <= {vpipe[PIPE_DEPTH-2:0], in_valid};
      out_valid <= vpipe[PIPE_DEPTH-1];
    end
  end

  mwm_mix u_mix (
    .clk          (clk),
    .en           (en),
    .vel_forward  (vel_forward),
    .vel_sideways (vel_sideways),
    .vel_rotate   (vel_rotate),
    .mag          (mag),
    .neg          (neg),
    .wlow         (wlow),
    .max_front    (max_front),
    .max_rear     (max_rear)
  );

  mwm_mult u_mult (
    .clk         (clk),
    .en          (en),
    .speed_limit (speed_limit),
    .mag         (mag),
    .neg         (neg),
    .wlow        (wlow),
    .max_front   (max_front),
    .max_rear    (max_rear),
    .prod        (prod),
    .largest     (largest),
    .side        (side)
  );

  for (genvar i = 0; i < WHEELS; i++) begin : g_div
    mwm_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (prod[i]),
      .divisor  (largest),
      .quotient (quo[i])
    );
  end

  // Side data delayed to line up with the divider output
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      if (!side_d[DIV_STAGES-1].scale) begin
        result_next[i] = side_d[DIV_STAGES-1].wlow[i];
      end else if (side_d[DIV_STAGES-1].neg[i]) begin
        result_next[i] = VEL_W'(0) - VEL_W'(quo[i]);
      end else begin
        result_next[i] = VEL_W'(quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_left  <= result_next[FL];
      front_right <= result_next[FR];
      rear_left   <= result_next[RL];
      rear_right  <= result_next[RR];
    end
  end

  // Scaling is only chosen when the largest magnitude beats the limit, so never by zero
  a_no_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    (vpipe[2] && side.scale) |-> (largest != '0))
    else $error("scaling selected with a zero divisor");

  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid set right after reset");

  a_hold_upstream: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(vpipe)))
    else $error("pipeline moved while the output was stalled");

endmodule
